// ----- rtl/clrc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the collision and lane risk classifier.
// Item and result types, status codes, register indexes and arithmetic constants.
package clrc_pkg;

	localparam int NUM_W = 47;
	localparam int DEN_W = 32;
	localparam int Q_W = 16;

	localparam logic [1:0] ST_SAFE = 2'd0;
	localparam logic [1:0] ST_ATTN = 2'd1;
	localparam logic [1:0] ST_RISK = 2'd2;

	localparam logic REG_FRICTION = 1'b0;
	localparam logic REG_SENS = 1'b1;

	localparam logic [1:0] SENS_SPORTY = 2'd1;
	localparam logic [1:0] SENS_NORMAL = 2'd2;

	localparam logic [9:0] FRICTION_RST = 10'd179;
	localparam logic [1:0] SENS_RST = 2'd2;

	// h * 397305 for h = 2, 3, 4 half-seconds
	localparam logic [20:0] HK_SPORTY = 21'd794610;
	localparam logic [20:0] HK_NORMAL = 21'd1191915;
	localparam logic [20:0] HK_SAFE = 21'd1589220;
	localparam logic [21:0] DEN_K = 22'd2860596;
	localparam logic [14:0] SQ_K = 15'd28800;

	localparam logic [14:0] SPEED_KNEE = 15'd8000;
	localparam logic [14:0] MARGIN_BASE = 15'd5000;
	localparam logic [14:0] MARGIN_BAND = 15'd2000;

	typedef struct packed {
		logic [14:0] own_speed;
		logic [14:0] lead_speed;
		logic signed [15:0] radar_range;
		logic signed [15:0] lidar_range;
		logic signed [15:0] camera_range;
		logic [13:0] left_lane_gap;
		logic [13:0] right_lane_gap;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] fused_range;
		logic [15:0] safe_range;
		logic [1:0] frontal_status;
		logic [1:0] left_lane_status;
		logic [1:0] right_lane_status;
		logic [1:0] overall_status;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] fused;
		logic closing;
		logic [1:0] left;
		logic [1:0] right;
	} side_t;

endpackage

// ----- rtl/clrc_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider for the safe distance, 16 quotient bits, saturating.
// Uses clrc_pkg; carries a side payload along with each item.
module clrc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [clrc_pkg::NUM_W-1:0] num,
	input  logic [clrc_pkg::DEN_W-1:0] den,
	input  clrc_pkg::side_t in_side,
	output logic out_valid,
	output logic [clrc_pkg::Q_W-1:0] quot,
	output clrc_pkg::side_t out_side
);

	localparam int NS = clrc_pkg::Q_W;
	localparam int CW = clrc_pkg::NUM_W + 1;

	logic vld_s [0:NS];
	logic [clrc_pkg::NUM_W-1:0] rem_s [0:NS];
	logic [clrc_pkg::DEN_W-1:0] den_s [0:NS];
	logic [NS-1:0] quo_s [0:NS];
	logic sat_s [0:NS];
	logic zero_s [0:NS];
	clrc_pkg::side_t side_s [0:NS];

	logic [CW-1:0] den_top;
	assign den_top = {den, {(CW - clrc_pkg::DEN_W){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		sat_s[0] <= ({1'b0, num} >= den_top) && (num != '0);
		zero_s[0] <= (num == '0);
		side_s[0] <= in_side;
	end

	for (genvar g = 0; g < NS; g++) begin : g_step
		logic [CW-1:0] dsh;
		logic [CW-1:0] rx;
		logic [CW-1:0] diff;
		logic ge;
		assign dsh = {{(CW - clrc_pkg::DEN_W){1'b0}}, den_s[g]} << (NS - 1 - g);
		assign rx = {1'b0, rem_s[g]};
		assign ge = rx >= dsh;
		assign diff = rx - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= ge ? diff[clrc_pkg::NUM_W-1:0] : rem_s[g];
			den_s[g+1] <= den_s[g];
			quo_s[g+1] <= {quo_s[g][NS-2:0], ge};
			sat_s[g+1] <= sat_s[g];
			zero_s[g+1] <= zero_s[g];
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid = vld_s[NS];
	assign out_side = side_s[NS];
	assign quot = zero_s[NS] ? '0 : (sat_s[NS] ? '1 : quo_s[NS]);

endmodule

// ----- rtl/collision_and_lane_risk_classifier.sv -----
`timescale 1ns / 1ps
// Collision and lane risk classifier: one item per clock. Items pass through stages 1 to 3,
// the divider for the safe distance and the output stage; throughput is one item
// every cycle and busy stays low. The receiver cannot stall, so the pipeline never holds.
// Reset clears all valid bits and loads friction 179 and sensitivity mode 2.
// Uses clrc_pkg and clrc_div.
module collision_and_lane_risk_classifier (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  clrc_pkg::in_item_t item,
	output logic done,
	output clrc_pkg::out_item_t result,
	input  logic write_en,
	input  logic reg_index,
	input  logic [9:0] write_data
);

	logic [9:0] friction_q;
	logic [1:0] sens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			friction_q <= clrc_pkg::FRICTION_RST;
			sens_q <= clrc_pkg::SENS_RST;
		end else if (write_en) begin
			case (reg_index)
				clrc_pkg::REG_FRICTION: friction_q <= write_data;
				clrc_pkg::REG_SENS: sens_q <= write_data[1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic take;
	assign take = start && !busy;

	// stage 1: median, lane classes, first products
	logic signed [15:0] mn_ab, mx_ab, mn_mc, fused_c;
	logic [14:0] margin_c, margin_hi_c;
	logic [17:0] lg_c, rg_c;
	logic [20:0] hk_c;

	always_comb begin
		mn_ab = (item.radar_range < item.lidar_range) ? item.radar_range
			: item.lidar_range;
		mx_ab = (item.radar_range < item.lidar_range) ? item.lidar_range
			: item.radar_range;
		mn_mc = (mx_ab < item.camera_range) ? mx_ab : item.camera_range;
		fused_c = (mn_ab > mn_mc) ? mn_ab : mn_mc;
		margin_c = clrc_pkg::MARGIN_BASE;
		if (item.own_speed > clrc_pkg::SPEED_KNEE)
			margin_c = clrc_pkg::MARGIN_BASE + (item.own_speed - clrc_pkg::SPEED_KNEE);
		margin_hi_c = margin_c + clrc_pkg::MARGIN_BAND;
		lg_c = {4'd0, item.left_lane_gap} * 18'd10;
		rg_c = {4'd0, item.right_lane_gap} * 18'd10;
		case (sens_q)
			clrc_pkg::SENS_SPORTY: hk_c = clrc_pkg::HK_SPORTY;
			clrc_pkg::SENS_NORMAL: hk_c = clrc_pkg::HK_NORMAL;
			default: hk_c = clrc_pkg::HK_SAFE;
		endcase
	end

	function automatic logic [1:0] lane_class(input logic [17:0] g,
		input logic [14:0] lo, input logic [14:0] hi);
		logic [1:0] r;
		if (g < {3'd0, lo})
			r = clrc_pkg::ST_RISK;
		else if (g < {3'd0, hi})
			r = clrc_pkg::ST_ATTN;
		else
			r = clrc_pkg::ST_SAFE;
		return r;
	endfunction

	logic vld_s1;
	logic [24:0] sf_s1;
	logic [29:0] ss_s1;
	logic [20:0] hk_s1;
	logic [clrc_pkg::DEN_W-1:0] den_s1;
	clrc_pkg::side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		sf_s1 <= {10'd0, item.own_speed} * {15'd0, friction_q};
		ss_s1 <= {15'd0, item.own_speed} * {15'd0, item.own_speed};
		hk_s1 <= hk_c;
		den_s1 <= {10'd0, clrc_pkg::DEN_K} * {22'd0, friction_q};
		side_s1.fused <= fused_c;
		side_s1.closing <= item.own_speed > item.lead_speed;
		side_s1.left <= lane_class(lg_c, margin_c, margin_hi_c);
		side_s1.right <= lane_class(rg_c, margin_c, margin_hi_c);
	end

	// stage 2: numerator terms
	logic vld_s2;
	logic [45:0] p1_s2;
	logic [44:0] p2_s2;
	logic [clrc_pkg::DEN_W-1:0] den_s2;
	clrc_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p1_s2 <= {21'd0, sf_s1} * {25'd0, hk_s1};
		p2_s2 <= {15'd0, ss_s1} * {30'd0, clrc_pkg::SQ_K};
		den_s2 <= den_s1;
		side_s2 <= side_s1;
	end

	// stage 3: numerator sum
	logic vld_s3;
	logic [clrc_pkg::NUM_W-1:0] num_s3;
	logic [clrc_pkg::DEN_W-1:0] den_s3;
	clrc_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_s3 <= {1'b0, p1_s2} + {2'd0, p2_s2};
		den_s3 <= den_s2;
		side_s3 <= side_s2;
	end

	logic div_vld;
	logic [clrc_pkg::Q_W-1:0] div_q;
	clrc_pkg::side_t div_side;

	clrc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s3),
		.num(num_s3),
		.den(den_s3),
		.in_side(side_s3),
		.out_valid(div_vld),
		.quot(div_q),
		.out_side(div_side)
	);

	// output stage: frontal class and overall maximum
	logic signed [17:0] fz, fz2, sz;
	logic [1:0] front_c, ovr_c;

	always_comb begin
		fz = {{2{div_side.fused[15]}}, div_side.fused};
		fz2 = fz <<< 1;
		sz = {2'b00, div_q};
		if (!div_side.closing || fz >= sz)
			front_c = clrc_pkg::ST_SAFE;
		else if (fz2 >= sz)
			front_c = clrc_pkg::ST_ATTN;
		else
			front_c = clrc_pkg::ST_RISK;
		ovr_c = front_c;
		if (div_side.left > ovr_c)
			ovr_c = div_side.left;
		if (div_side.right > ovr_c)
			ovr_c = div_side.right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.fused_range <= div_side.fused;
		result.safe_range <= div_q;
		result.frontal_status <= front_c;
		result.left_lane_status <= div_side.left;
		result.right_lane_status <= div_side.right;
		result.overall_status <= ovr_c;
	end

	a_overall_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.overall_status >= result.frontal_status)
			&& (result.overall_status >= result.left_lane_status)
			&& (result.overall_status >= result.right_lane_status))
		else $error("overall status below a component status");

	a_front_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($signed({result.fused_range[15], result.fused_range[15],
			result.fused_range}) >= $signed({2'b00, result.safe_range})))
		|-> (result.frontal_status == clrc_pkg::ST_SAFE))
		else $error("frontal risk flagged with range beyond safe distance");

	a_pipe_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(div_vld))
		else $error("result strobe without a divider item");

endmodule

// ----- dv/clrc_checker.sv -----
`timescale 1ns / 1ps
// Checker for the collision and lane risk classifier: follows register writes,
// predicts the result of every accepted item and compares it on the done strobe.
// Depends on clrc_pkg for the item types, status codes and register indexes.
module clrc_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  clrc_pkg::in_item_t item,
	input  logic done,
	input  clrc_pkg::out_item_t result,
	input  logic write_en,
	input  logic reg_index,
	input  logic [9:0] write_data,
	output int faults,
	output int outstanding
);

	// 100 cm * (1/3.6 m/s per km/h) * 0.5 s, and the braking term scale
	localparam longint unsigned REACT_K = 397305;
	localparam longint unsigned BRAKE_K = 28800;
	localparam longint unsigned DIV_K = 2860596;

	logic [9:0] friction;
	logic [1:0] sens_mode;
	clrc_pkg::out_item_t awaited_results[$];
	clrc_pkg::out_item_t want;

	function automatic logic [15:0] safe_cm(input logic [14:0] speed, input logic [9:0] fric,
			input logic [1:0] mode);
		longint unsigned s, h, num, den, q;
		s = speed;
		if (mode == clrc_pkg::SENS_SPORTY)
			h = 2;
		else if (mode == clrc_pkg::SENS_NORMAL)
			h = 3;
		else
			h = 4;
		if (fric == 10'd0)
			return (speed != 15'd0) ? 16'hFFFF : 16'h0000;
		num = s * h * REACT_K * longint'(fric) + s * s * BRAKE_K;
		den = DIV_K * longint'(fric);
		q = num / den;
		return (q > 65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [1:0] lane_level(input logic [13:0] gap_mm, input int unsigned margin);
		int unsigned g;
		g = gap_mm;
		g = g * 10;
		if (g < margin)
			return clrc_pkg::ST_RISK;
		if (g < margin + 2000)
			return clrc_pkg::ST_ATTN;
		return clrc_pkg::ST_SAFE;
	endfunction

	function automatic clrc_pkg::out_item_t classify_sample(input clrc_pkg::in_item_t it,
			input logic [9:0] fric, input logic [1:0] mode);
		clrc_pkg::out_item_t r;
		int a, b, c, lo, hi, med;
		longint sf, fz;
		int unsigned margin;
		a = it.radar_range;
		b = it.lidar_range;
		c = it.camera_range;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		med = (c < lo) ? lo : ((c > hi) ? hi : c);
		r.fused_range = med[15:0];
		r.safe_range = safe_cm(it.own_speed, fric, mode);
		sf = r.safe_range;
		fz = med;
		if (it.own_speed <= it.lead_speed || fz >= sf)
			r.frontal_status = clrc_pkg::ST_SAFE;
		else if (2 * fz >= sf)
			r.frontal_status = clrc_pkg::ST_ATTN;
		else
			r.frontal_status = clrc_pkg::ST_RISK;
		margin = 5000;
		if (it.own_speed > 15'd8000)
			margin = margin + it.own_speed - 8000;
		r.left_lane_status = lane_level(it.left_lane_gap, margin);
		r.right_lane_status = lane_level(it.right_lane_gap, margin);
		r.overall_status = r.frontal_status;
		if (r.left_lane_status > r.overall_status)
			r.overall_status = r.left_lane_status;
		if (r.right_lane_status > r.overall_status)
			r.overall_status = r.right_lane_status;
		return r;
	endfunction

	initial begin
		faults = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			friction = clrc_pkg::FRICTION_RST;
			sens_mode = clrc_pkg::SENS_RST;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					faults++;
					$display("%0t: result with no item pending: fused=%0d safe=%0d st=%0d/%0d/%0d/%0d",
						$time, result.fused_range, result.safe_range, result.frontal_status,
						result.left_lane_status, result.right_lane_status, result.overall_status);
				end else begin
					want = awaited_results.pop_front();
					if (result !== want) begin
						faults++;
						$display("%0t: mismatch expected fused=%0d safe=%0d st=%0d/%0d/%0d/%0d",
							$time, want.fused_range, want.safe_range, want.frontal_status,
							want.left_lane_status, want.right_lane_status, want.overall_status);
						$display("%0t:          actual   fused=%0d safe=%0d st=%0d/%0d/%0d/%0d",
							$time, result.fused_range, result.safe_range, result.frontal_status,
							result.left_lane_status, result.right_lane_status, result.overall_status);
					end
				end
			end
			if (start && !busy)
				awaited_results.push_back(classify_sample(item, friction, sens_mode));
			if (write_en) begin
				case (reg_index)
					clrc_pkg::REG_FRICTION: friction = write_data;
					clrc_pkg::REG_SENS: sens_mode = write_data[1:0];
					default: ;
				endcase
			end
			outstanding = awaited_results.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the collision and lane risk classifier testbench: clock, reset, register
// settings and item stimulus; checking is in clrc_checker. Depends on clrc_pkg.
module tb_top;

	localparam int LIMIT = 200000;
	localparam int DRAIN = 40;
	localparam int PER_PHASE = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	clrc_pkg::in_item_t item = '0;
	logic done;
	clrc_pkg::out_item_t result;
	logic write_en = 1'b0;
	logic reg_index = clrc_pkg::REG_FRICTION;
	logic [9:0] write_data = '0;
	int faults, outstanding;
	int cycles = 0;
	int idle_pct = 0;
	logic [9:0] cur_fric;
	logic [1:0] cur_sens;
	int fric_set[8] = '{179, 1, 512, 1023, 0, 300, 0, -1};
	int sens_set[8] = '{2, 1, 3, 0, 2, 1, 3, -1};
	int s10k;

	always #5 clk = ~clk;

	collision_and_lane_risk_classifier dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .write_en(write_en), .reg_index(reg_index),
		.write_data(write_data)
	);

	clrc_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .write_en(write_en), .reg_index(reg_index),
		.write_data(write_data), .faults(faults), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic clrc_pkg::in_item_t mk(input int own, input int lead, input int ra,
			input int li, input int ca, input int lg, input int rg);
		clrc_pkg::in_item_t it;
		it.own_speed = own[14:0];
		it.lead_speed = lead[14:0];
		it.radar_range = ra[15:0];
		it.lidar_range = li[15:0];
		it.camera_range = ca[15:0];
		it.left_lane_gap = lg[13:0];
		it.right_lane_gap = rg[13:0];
		return it;
	endfunction

	function automatic clrc_pkg::in_item_t noise_item();
		logic [127:0] n;
		n = {$urandom, $urandom, $urandom, $urandom};
		return clrc_pkg::in_item_t'(n[$bits(clrc_pkg::in_item_t)-1:0]);
	endfunction

	function automatic int rand_gap(input int margin);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 16383);
			1: return margin / 10 + int'($urandom_range(0, 4)) - 2;
			2: return (margin + 2000) / 10 + int'($urandom_range(0, 4)) - 2;
			default: return $urandom_range(0, 10000);
		endcase
	endfunction

	function automatic clrc_pkg::in_item_t rand_item();
		int own, lead, target, safe, margin;
		clrc_pkg::in_item_t it;
		case ($urandom_range(0, 7))
			0: own = 0;
			1: own = $urandom_range(0, 32767);
			2: own = $urandom_range(7990, 8010);
			default: own = $urandom_range(0, 30000);
		endcase
		case ($urandom_range(0, 3))
			0: lead = $urandom_range(0, 32767);
			1: lead = own;
			default: begin
				lead = own - int'($urandom_range(0, 300));
				if (lead < 0)
					lead = 0;
			end
		endcase
		safe = int'(chk.safe_cm(own[14:0], cur_fric, cur_sens));
		margin = (own > 8000) ? 5000 + own - 8000 : 5000;
		it = mk(own, lead, 0, 0, 0, rand_gap(margin), rand_gap(margin));
		case ($urandom_range(0, 3))
			0: target = -1;
			1: target = safe;
			2: target = safe / 2;
			default: target = $urandom_range(0, 30000);
		endcase
		if (target < 0) begin
			it.radar_range = 16'($urandom);
			it.lidar_range = 16'($urandom);
			it.camera_range = 16'($urandom);
		end else begin
			it.radar_range = 16'(target + int'($urandom_range(0, 8)) - 4);
			it.lidar_range = 16'(target + int'($urandom_range(0, 8)) - 4);
			it.camera_range = 16'(target + int'($urandom_range(0, 8)) - 4);
			if ($urandom_range(0, 3) == 0)
				it.camera_range = 16'($urandom);
		end
		return it;
	endfunction

	task automatic send_item(input clrc_pkg::in_item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			item <= noise_item();
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until every result is back, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] d);
		@(negedge clk);
		write_en <= 1'b1;
		reg_index <= idx;
		write_data <= d;
		@(negedge clk);
		write_en <= 1'b0;
	endtask

	initial begin
		int f, s;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		cur_fric = clrc_pkg::FRICTION_RST;
		cur_sens = clrc_pkg::SENS_RST;
		idle_pct = 28;
		s10k = int'(chk.safe_cm(15'd10000, cur_fric, cur_sens));

		send_item(mk(0, 0, 0, 0, 0, 0, 0));
		send_item(mk(32767, 0, 32767, 32767, 32767, 16383, 16383));
		send_item(mk(32767, 32767, -32768, -32768, -32768, 0, 0));
		send_item(mk(30000, 0, -32768, 32767, 0, 10000, 10000));
		send_item(mk(20000, 10000, 1, 2, 3, 5000, 5000));
		send_item(mk(20000, 10000, 3, 1, 2, 5000, 5000));
		send_item(mk(20000, 10000, 2, 3, 1, 5000, 5000));
		send_item(mk(20000, 10000, 5, 5, -7, 5000, 5000));
		send_item(mk(8000, 0, 30000, 30000, 30000, 499, 500));
		send_item(mk(8000, 0, 30000, 30000, 30000, 699, 700));
		send_item(mk(8001, 0, 30000, 30000, 30000, 500, 700));
		send_item(mk(10000, 9999, s10k, s10k, s10k, 8000, 8000));
		send_item(mk(10000, 9999, s10k - 1, s10k - 1, s10k - 1, 8000, 8000));
		send_item(mk(10000, 9999, (s10k + 1) / 2, (s10k + 1) / 2, 0, 8000, 8000));
		send_item(mk(10000, 9999, (s10k + 1) / 2 - 1, 32767, -1, 8000, 8000));
		send_item(mk(10000, 10000, -1, -1, -1, 8000, 8000));
		send_item(mk(10000, 10001, -32768, 0, 0, 16383, 0));

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			f = (fric_set[ph] < 0) ? $urandom_range(0, 1023) : fric_set[ph];
			s = (sens_set[ph] < 0) ? $urandom_range(0, 3) : sens_set[ph];
			cur_fric = f[9:0];
			cur_sens = s[1:0];
			write_reg(clrc_pkg::REG_FRICTION, cur_fric);
			write_reg(clrc_pkg::REG_SENS, {8'($urandom), cur_sens});
			idle_pct = (ph < 3) ? 28 : ((ph < 6) ? 53 : 0);
			repeat (PER_PHASE) send_item(rand_item());
		end

		settle();
		if (faults == 0 && outstanding == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/clrc_pkg.sv
rtl/clrc_div.sv
rtl/collision_and_lane_risk_classifier.sv
dv/clrc_checker.sv
dv/tb_top.sv
